[sv/hvd_pkg.sv]
// shared types, constants and tables of the haversine angular distance block
`default_nettype none

package hvd_pkg;

	typedef logic [28:0]        ra_t;
	typedef logic signed [27:0] dec_t;
	typedef logic [29:0]        sep_t;

	localparam int CORDIC_STAGES = 24;

	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

	// phase = round(m * 2^23 / 703125) for full angles, 2^22 for half angles
	localparam logic [19:0] DIV_K      = 20'd703125;
	localparam logic [31:0] DIV_RECIP  = 32'd3202559735;
	localparam logic [19:0] HALF_ROUND = 20'd351562;

	localparam logic [60:0] ONE_Q60       = 61'(1) << 60;
	localparam logic [30:0] MAS_TURN      = 31'd1296000000;
	localparam logic [29:0] MAS_HALF_TURN = 30'd648000000;

	function automatic logic [31:0] atan_at(input int i);
		logic [31:0] a;
		unique case (i)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			24: a = 32'd41;
			25: a = 32'd20;
			26: a = 32'd10;
			27: a = 32'd5;
			28: a = 32'd3;
			29: a = 32'd1;
			30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

[sv/hvd_in_if.sv]
// input channel: a pair of sky positions
`default_nettype none

interface hvd_in_if import hvd_pkg::*; ();
	logic valid;
	logic ready;
	ra_t  ra_first;
	dec_t dec_first;
	ra_t  ra_second;
	dec_t dec_second;

	modport source (output valid, ra_first, dec_first, ra_second, dec_second, input ready);
	modport sink (input valid, ra_first, dec_first, ra_second, dec_second, output ready);
endinterface

`default_nettype wire

[sv/hvd_out_if.sv]
// output channel: great-circle separation
`default_nettype none

interface hvd_out_if import hvd_pkg::*; ();
	logic valid;
	logic ready;
	sep_t separation_mas;

	modport source (output valid, separation_mas, input ready);
	modport sink (input valid, separation_mas, output ready);
endinterface

`default_nettype wire

[sv/haversine_angular_distance_core.sv]
// haversine great-circle separation of two sky positions, top level
//
// in_ch takes one item per cycle unless out_ch stalls: ra_first, dec_first,
// ra_second and dec_second in micro-degrees. out_ch gives one item per
// input item, separation_mas in milliarcseconds, saturated at 180 degrees,
// in input order. The block is one pipeline with no feedback; an item may
// enter in every cycle that in_ch.ready is high. The stages in order: input
// register, phase conversion, the rotation cordic with its quadrant split
// and fix-up, products and clamp, square root, the vectoring cordic and
// scaling into the output register. Throughput is one item per cycle.
// All stages advance together. When out_ch holds a result that is not taken,
// the whole pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// Reset (arst_n low) clears every valid bit; items in flight are dropped and
// the block is ready again right after reset is released.
`default_nettype none

module haversine_angular_distance_core import hvd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hvd_in_if.sink     in_ch,
	hvd_out_if.source  out_ch
);

	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		logic signed [31:0] a;
		a = v[31] ? -v : v;
		return a[30:0];
	endfunction

	logic en;

	// input register
	logic        vld_s1;
	logic [28:0] m_dec1_s1, m_dec2_s1, m_ddec_s1, m_dra_s1;
	logic        n_dec1_s1, n_dec2_s1, n_ddec_s1, n_dra_s1;

	logic signed [28:0] ddec;
	logic signed [29:0] dra;
	logic [27:0]        a_dec1, a_dec2;
	logic [28:0]        a_ddec;
	logic [29:0]        a_dra;

	logic        ph_vld;
	logic [31:0] ph_dec1, ph_dec2, ph_ddec, ph_dra;

	logic               sc_vld;
	logic signed [31:0] c1, c2, sd, sr;

	logic        vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [61:0] sdsq_s2, sdsq_s3;
	logic [31:0] p_s2, q_s2;
	logic        neg_s2, neg_s3;
	logic [63:0] term_s3;
	logic [60:0] hav_s4, hav_s5, comp_s5;
	logic [61:0] pw, qw;
	logic [64:0] hv;

	logic        sq_vld;
	logic [30:0] root_hav, root_comp;

	logic               at_vld;
	logic signed [33:0] z;
	logic [62:0]        mprod_s6;
	logic [31:0]        zc;
	logic [32:0]        mas;

	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_comb begin
		ddec   = 29'(in_ch.dec_second) - 29'(in_ch.dec_first);
		dra    = signed'(30'(in_ch.ra_second)) - signed'(30'(in_ch.ra_first));
		a_dec1 = in_ch.dec_first[27] ? 28'(-in_ch.dec_first) : in_ch.dec_first;
		a_dec2 = in_ch.dec_second[27] ? 28'(-in_ch.dec_second) : in_ch.dec_second;
		a_ddec = ddec[28] ? 29'(-ddec) : ddec;
		a_dra  = dra[29] ? 30'(-dra) : dra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_dec1_s1 <= 29'(a_dec1);
			m_dec2_s1 <= 29'(a_dec2);
			m_ddec_s1 <= a_ddec;
			m_dra_s1  <= a_dra[28:0];
			n_dec1_s1 <= in_ch.dec_first[27];
			n_dec2_s1 <= in_ch.dec_second[27];
			n_ddec_s1 <= ddec[28];
			n_dra_s1  <= dra[29];
		end
	end

	hvd_phase u_ph_dec1 (
		.clk, .arst_n, .en, .vld_in(vld_s1), .half(1'b0), .mag(m_dec1_s1),
		.neg(n_dec1_s1), .vld_out(ph_vld), .phase(ph_dec1)
	);
	hvd_phase u_ph_dec2 (
		.clk, .arst_n, .en, .vld_in(vld_s1), .half(1'b0), .mag(m_dec2_s1),
		.neg(n_dec2_s1), .vld_out(), .phase(ph_dec2)
	);
	hvd_phase u_ph_ddec (
		.clk, .arst_n, .en, .vld_in(vld_s1), .half(1'b1), .mag(m_ddec_s1),
		.neg(n_ddec_s1), .vld_out(), .phase(ph_ddec)
	);
	hvd_phase u_ph_dra (
		.clk, .arst_n, .en, .vld_in(vld_s1), .half(1'b1), .mag(m_dra_s1),
		.neg(n_dra_s1), .vld_out(), .phase(ph_dra)
	);

	hvd_sincos u_sc_dec1 (
		.clk, .arst_n, .en, .vld_in(ph_vld), .phase(ph_dec1),
		.vld_out(sc_vld), .c(c1), .s()
	);
	hvd_sincos u_sc_dec2 (
		.clk, .arst_n, .en, .vld_in(ph_vld), .phase(ph_dec2),
		.vld_out(), .c(c2), .s()
	);
	hvd_sincos u_sc_ddec (
		.clk, .arst_n, .en, .vld_in(ph_vld), .phase(ph_ddec),
		.vld_out(), .c(), .s(sd)
	);
	hvd_sincos u_sc_dra (
		.clk, .arst_n, .en, .vld_in(ph_vld), .phase(ph_dra),
		.vld_out(), .c(), .s(sr)
	);

	always_comb begin
		pw = 62'(mag31(c1)) * 62'(mag31(sr));
		qw = 62'(mag31(c2)) * 62'(mag31(sr));
		// a zero term gives the same hav on either branch
		if (neg_s3) begin
			hv = (65'(sdsq_s3) > 65'(term_s3)) ? 65'(sdsq_s3) - 65'(term_s3) : 65'd0;
		end else begin
			hv = 65'(sdsq_s3) + 65'(term_s3);
		end
		zc  = z[33] ? 32'd0 : z[31:0];
		mas = 33'((64'(mprod_s6) + (64'(1) << 30)) >> 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			vld_s5       <= 1'b0;
			vld_s6       <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (en) begin
			vld_s2       <= sc_vld;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			vld_s6       <= at_vld;
			out_ch.valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sdsq_s2 <= 62'(mag31(sd)) * 62'(mag31(sd));
			p_s2    <= pw[61:30];
			q_s2    <= qw[61:30];
			neg_s2  <= c1[31] != c2[31];
			term_s3 <= 64'(p_s2) * 64'(q_s2);
			sdsq_s3 <= sdsq_s2;
			neg_s3  <= neg_s2;
			hav_s4  <= (hv > 65'(ONE_Q60)) ? ONE_Q60 : hv[60:0];
			hav_s5  <= hav_s4;
			comp_s5 <= ONE_Q60 - hav_s4;
			mprod_s6 <= 63'(zc) * 63'(MAS_TURN);
			out_ch.separation_mas <= (mas > 33'(MAS_HALF_TURN)) ? MAS_HALF_TURN : mas[29:0];
		end
	end

	hvd_isqrt u_sq_hav (
		.clk, .arst_n, .en, .vld_in(vld_s5), .v(hav_s5),
		.vld_out(sq_vld), .root(root_hav)
	);
	hvd_isqrt u_sq_comp (
		.clk, .arst_n, .en, .vld_in(vld_s5), .v(comp_s5),
		.vld_out(), .root(root_comp)
	);

	hvd_atan2 u_atan (
		.clk, .arst_n, .en, .vld_in(sq_vld), .x(root_comp), .y(root_hav),
		.vld_out(at_vld), .z(z)
	);

endmodule

`default_nettype wire

[sv/hvd_phase.sv]
// micro-degree magnitude to 32-bit phase, reciprocal multiply with correction
`default_nettype none

module hvd_phase import hvd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld_in,
	input  wire logic        half,
	input  wire logic [28:0] mag,
	input  wire logic        neg,
	output logic             vld_out,
	output logic [31:0]      phase
);

	logic        vld_s1, vld_s2;
	logic [60:0] prod_s1;
	logic [28:0] mag_s1;
	logic        neg_s1, half_s1, neg_s2;
	logic [32:0] qe_s2;
	logic [21:0] rem_s2;

	logic [32:0] qe;
	logic [51:0] num;
	logic [52:0] qk;
	logic [53:0] rem;
	logic [1:0]  corr;
	logic [32:0] q;

	always_comb begin
		qe   = half_s1 ? 33'(prod_s1 >> 29) : 33'(prod_s1 >> 28);
		num  = (half_s1 ? (52'(mag_s1) << 22) : (52'(mag_s1) << 23)) + 52'(HALF_ROUND);
		qk   = 53'(qe) * 53'(DIV_K);
		rem  = 54'(num) - 54'(qk);
		// estimate is low by at most three
		corr = 2'(22'(rem_s2) >= 22'(DIV_K)) + 2'(rem_s2 >= 22'(2 * DIV_K))
			+ 2'(rem_s2 >= 22'(3 * DIV_K));
		q    = qe_s2 + 33'(corr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_out <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 61'(mag) * 61'(DIV_RECIP);
			mag_s1  <= mag;
			neg_s1  <= neg;
			half_s1 <= half;
			qe_s2   <= qe;
			rem_s2  <= rem[21:0];
			neg_s2  <= neg_s1;
			phase   <= neg_s2 ? 32'(-q) : q[31:0];
		end
	end

endmodule

`default_nettype wire

[sv/hvd_sincos.sv]
// rotation-mode cordic: cosine and sine of a 32-bit phase, q30
`default_nettype none

module hvd_sincos import hvd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld_in,
	input  wire logic [31:0] phase,
	output logic             vld_out,
	output logic signed [31:0] c,
	output logic signed [31:0] s
);

	logic               vld_s0;
	logic [1:0]         quad_s0;
	logic signed [31:0] z_s0;

	logic               vld_s [0:CORDIC_STAGES-1];
	logic signed [31:0] x_s   [0:CORDIC_STAGES-1];
	logic signed [31:0] y_s   [0:CORDIC_STAGES-1];
	logic signed [31:0] z_s   [0:CORDIC_STAGES-1];
	logic [1:0]         quad_s [0:CORDIC_STAGES-1];

	logic [31:0] padd;
	logic [1:0]  quad;

	assign padd = phase + 32'h2000_0000;
	assign quad = padd[31:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s0 <= quad;
			z_s0    <= signed'(phase - {quad, 30'b0});
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stg
		localparam logic signed [31:0] ATAN = signed'(atan_at(i));
		logic               vi;
		logic signed [31:0] xi, yi, zi;
		logic [1:0]         qi;

		if (i == 0) begin : g_first
			assign vi = vld_s0;
			assign xi = CORDIC_GAIN_Q30;
			assign yi = 32'sd0;
			assign zi = z_s0;
			assign qi = quad_s0;
		end else begin : g_next
			assign vi = vld_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign qi = quad_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i] <= qi;
				if (!zi[31]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN;
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_s[CORDIC_STAGES-1];
		end
	end

	// quadrant applied exactly after the residue rotation
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s[CORDIC_STAGES-1])
				2'd1: begin
					c <= -y_s[CORDIC_STAGES-1];
					s <= x_s[CORDIC_STAGES-1];
				end
				2'd2: begin
					c <= -x_s[CORDIC_STAGES-1];
					s <= -y_s[CORDIC_STAGES-1];
				end
				2'd3: begin
					c <= y_s[CORDIC_STAGES-1];
					s <= -x_s[CORDIC_STAGES-1];
				end
				default: begin
					c <= x_s[CORDIC_STAGES-1];
					s <= y_s[CORDIC_STAGES-1];
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/hvd_isqrt.sv]
// pipelined floor square root of a q60 value, one result bit per stage
`default_nettype none

module hvd_isqrt import hvd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld_in,
	input  wire logic [60:0] v,
	output logic             vld_out,
	output logic [30:0]      root
);

	localparam int STEPS = 31;

	logic        vld_s [0:STEPS-1];
	logic [61:0] v_s   [0:STEPS-1];
	logic [61:0] r_s   [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_stp
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
		logic        vi;
		logic [61:0] xi, ri, sum;

		if (k == 0) begin : g_first
			assign vi = vld_in;
			assign xi = 62'(v);
			assign ri = 62'd0;
		end else begin : g_next
			assign vi = vld_s[k-1];
			assign xi = v_s[k-1];
			assign ri = r_s[k-1];
		end

		assign sum = ri + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (xi >= sum) begin
					v_s[k] <= xi - sum;
					r_s[k] <= (ri >> 1) + BIT;
				end else begin
					v_s[k] <= xi;
					r_s[k] <= ri >> 1;
				end
			end
		end
	end

	assign vld_out = vld_s[STEPS-1];
	assign root    = r_s[STEPS-1][30:0];

endmodule

`default_nettype wire

[sv/hvd_atan2.sv]
// vectoring-mode cordic: phase of (x, y)
`default_nettype none

module hvd_atan2 import hvd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld_in,
	input  wire logic [30:0] x,
	input  wire logic [30:0] y,
	output logic             vld_out,
	output logic signed [33:0] z
);

	logic               vld_s [0:CORDIC_STAGES-1];
	logic signed [32:0] x_s   [0:CORDIC_STAGES-1];
	logic signed [32:0] y_s   [0:CORDIC_STAGES-1];
	logic signed [33:0] z_s   [0:CORDIC_STAGES-1];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stg
		localparam logic signed [33:0] ATAN = signed'({2'b00, atan_at(i)});
		logic               vi;
		logic signed [32:0] xi, yi;
		logic signed [33:0] zi;

		if (i == 0) begin : g_first
			assign vi = vld_in;
			assign xi = signed'({2'b00, x});
			assign yi = signed'({2'b00, y});
			assign zi = 34'sd0;
		end else begin : g_next
			assign vi = vld_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		// rotate down while y is not negative
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[32]) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN;
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN;
				end
			end
		end
	end

	assign vld_out = vld_s[CORDIC_STAGES-1];
	assign z       = z_s[CORDIC_STAGES-1];

endmodule

`default_nettype wire
